// ===== src/jic_pkg.sv =====
// joystick input conditioner: shared widths, types and constants
// used by the top level and the serial axis shaper; no dependencies
`default_nettype none

package jic_pkg;

	localparam int SAMPLE_W  = 12;               // converter sample and centre width
	localparam int DZ_W      = 12;               // deadzone register width
	localparam int RANGE_W   = 11;               // full-scale register width
	localparam int POS_W     = 12;               // signed position width
	localparam int MAG_W     = RANGE_W;          // clamped magnitude width
	localparam int CUBE_W    = 3 * MAG_W;        // widest product (cube)
	localparam int CNT_W     = $clog2(MAG_W);    // digit counter width
	localparam int QUO_SHIFT = MAG_W - 1;        // first divisor alignment
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 1'd1;

	localparam logic [DZ_W-1:0]    DEADZONE_RST   = 12'd200;
	localparam logic [RANGE_W-1:0] FULL_SCALE_RST = 11'd800;

	// status of one axis shaper
	typedef struct packed {
		logic                    done;
		logic signed [POS_W-1:0] pos;
	} axis_stat_t;

endpackage

`default_nettype wire

// ===== src/joystick_input_conditioner.sv =====
// joystick_input_conditioner: centre capture, deadzone, clamp, cubic curve, fire edge
// one word in flight: a new word is taken only once the last result is loaded into the output
// register, which waits on out_ready; the work is the bit-serial multiply and divide (three
// multiplies and a divide) in each axis shaper, which an axis with zero offset skips
// reset: asynchronous, clears centre, calibration and press history; registers to defaults
// depends on jic_pkg and jic_axis_shaper
`default_nettype none

module joystick_input_conditioner #(
	parameter int ADC_BITS = 12
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output      logic                                 in_ready,
	input  wire logic [jic_pkg::SAMPLE_W-1:0]         adc_x,
	input  wire logic [jic_pkg::SAMPLE_W-1:0]         adc_y,
	input  wire logic                                 button_level,
	input  wire logic                                 recalibrate,
	output      logic                                 out_valid,
	input  wire logic                                 out_ready,
	output      logic signed [jic_pkg::POS_W-1:0]     pos_x,
	output      logic signed [jic_pkg::POS_W-1:0]     pos_y,
	output      logic                                 fire,
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [jic_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [jic_pkg::CFG_W-1:0]            cfg_data
);
	import jic_pkg::*;

	localparam int USE_BITS = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] ADC_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - USE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} top_state_t;

	top_state_t            state_q;
	logic [DZ_W-1:0]       deadzone_q;
	logic [RANGE_W-1:0]    full_scale_q;
	logic [SAMPLE_W-1:0]   center_x_q;
	logic [SAMPLE_W-1:0]   center_y_q;
	logic                  calibrated_q;
	logic                  was_pressed_q;
	logic                  fire_pend_q;
	logic                  out_valid_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic                  fire_q;

	logic                  accept;
	logic                  calib;
	logic                  pressed;
	logic [SAMPLE_W-1:0]   ax;
	logic [SAMPLE_W-1:0]   ay;
	logic [SAMPLE_W-1:0]   cx_new;
	logic [SAMPLE_W-1:0]   cy_new;
	logic                  both_done;
	logic                  out_free;
	logic                  load;
	axis_stat_t            stat_x;
	axis_stat_t            stat_y;

	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	// sample masking and centre selection
	assign ax      = adc_x & ADC_MASK;
	assign ay      = adc_y & ADC_MASK;
	assign calib   = recalibrate | ~calibrated_q;
	assign cx_new  = calib ? ax : center_x_q;
	assign cy_new  = calib ? ay : center_y_q;
	assign pressed = ~button_level;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q   <= DEADZONE_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEADZONE:   deadzone_q   <= cfg_data[DZ_W-1:0];
				REG_FULL_SCALE: full_scale_q <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	// centre, calibration and press history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			calibrated_q  <= 1'b0;
			was_pressed_q <= 1'b0;
			fire_pend_q   <= 1'b0;
		end else if (accept) begin
			center_x_q    <= cx_new;
			center_y_q    <= cy_new;
			calibrated_q  <= 1'b1;
			was_pressed_q <= pressed;
			fire_pend_q   <= pressed & ~was_pressed_q;
		end
	end

	// per-axis serial shapers
	jic_axis_shaper u_shape_x (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.sample     (ax),
		.center     (cx_new),
		.deadzone   (deadzone_q),
		.full_scale (full_scale_q),
		.stat       (stat_x)
	);

	jic_axis_shaper u_shape_y (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.sample     (ay),
		.center     (cy_new),
		.deadzone   (deadzone_q),
		.full_scale (full_scale_q),
		.stat       (stat_y)
	);

	assign both_done = stat_x.done & stat_y.done;
	assign out_free  = ~out_valid_q | out_ready;
	assign load      = (state_q != ST_IDLE) & both_done & out_free;

	// sequencing of one word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (both_done) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_x_q <= stat_x.pos;
			pos_y_q <= stat_y.pos;
			fire_q  <= fire_pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign fire      = fire_q;

endmodule

`default_nettype wire

// ===== src/jic_axis_shaper.sv =====
// one axis: deadzone, clamp and cubic curve v*v*v/(m*m) truncated to zero
// shift-add multiplies and a restoring divide, one bit per cycle; uses jic_pkg
`default_nettype none

module jic_axis_shaper (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [jic_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [jic_pkg::SAMPLE_W-1:0]  center,
	input  wire logic [jic_pkg::DZ_W-1:0]      deadzone,
	input  wire logic [jic_pkg::RANGE_W-1:0]   full_scale,
	output jic_pkg::axis_stat_t                stat
);
	import jic_pkg::*;

	typedef enum logic [5:0] {
		SH_IDLE = 6'b000001,
		SH_SQR  = 6'b000010,
		SH_CUBE = 6'b000100,
		SH_MSQ  = 6'b001000,
		SH_DIV  = 6'b010000,
		SH_DONE = 6'b100000
	} sh_state_t;

	sh_state_t            state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [MAG_W-1:0]     mag_q;
	logic [CUBE_W-1:0]    acc_q;
	logic [CUBE_W-1:0]    mcand_q;
	logic [MAG_W-1:0]     mplier_q;
	logic [CUBE_W-1:0]    rem_q;
	logic [CUBE_W-1:0]    div_q;
	logic [MAG_W-1:0]     quo_q;

	logic                 neg_c;
	logic [SAMPLE_W-1:0]  absd_c;
	logic [MAG_W-1:0]     mag_c;
	logic [CUBE_W-1:0]    acc_sum;
	logic                 last_digit;
	logic                 rem_ge;
	logic [POS_W-1:0]     quo_ext;

	// offset magnitude, deadzone and clamp
	always_comb begin
		neg_c  = sample < center;
		absd_c = neg_c ? (center - sample) : (sample - center);
		if (absd_c < {1'b0, deadzone[DZ_W-1:1]}) begin
			mag_c = '0;
		end else if (absd_c > {1'b0, full_scale}) begin
			mag_c = full_scale;
		end else begin
			mag_c = absd_c[MAG_W-1:0];
		end
	end

	// shared shift-add step and restoring divide compare
	assign acc_sum    = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign last_digit = cnt_q == CNT_W'(MAG_W - 1);
	assign rem_ge     = rem_q >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SH_IDLE;
			cnt_q   <= '0;
		end else begin
			cnt_q <= '0;
			case (state_q)
				SH_IDLE, SH_DONE: begin
					if (start) begin
						state_q <= (mag_c == '0) ? SH_DONE : SH_SQR;
					end
				end
				SH_SQR: begin
					cnt_q <= last_digit ? '0 : cnt_q + 1'b1;
					if (last_digit) begin
						state_q <= SH_CUBE;
					end
				end
				SH_CUBE: begin
					cnt_q <= last_digit ? '0 : cnt_q + 1'b1;
					if (last_digit) begin
						state_q <= SH_MSQ;
					end
				end
				SH_MSQ: begin
					cnt_q <= last_digit ? '0 : cnt_q + 1'b1;
					if (last_digit) begin
						state_q <= SH_DIV;
					end
				end
				SH_DIV: begin
					cnt_q <= last_digit ? '0 : cnt_q + 1'b1;
					if (last_digit) begin
						state_q <= SH_DONE;
					end
				end
				default: state_q <= SH_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			SH_IDLE, SH_DONE: begin
				if (start) begin
					neg_q    <= neg_c;
					mag_q    <= mag_c;
					acc_q    <= '0;
					mcand_q  <= CUBE_W'(mag_c);
					mplier_q <= mag_c;
					quo_q    <= '0;
				end
			end
			SH_SQR: begin
				if (last_digit) begin
					acc_q    <= '0;
					mcand_q  <= acc_sum;
					mplier_q <= mag_q;
				end else begin
					acc_q    <= acc_sum;
					mcand_q  <= {mcand_q[CUBE_W-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
				end
			end
			SH_CUBE: begin
				if (last_digit) begin
					rem_q    <= acc_sum;
					acc_q    <= '0;
					mcand_q  <= CUBE_W'(full_scale);
					mplier_q <= full_scale;
				end else begin
					acc_q    <= acc_sum;
					mcand_q  <= {mcand_q[CUBE_W-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
				end
			end
			SH_MSQ: begin
				if (last_digit) begin
					div_q <= {acc_sum[CUBE_W-1-QUO_SHIFT:0], {QUO_SHIFT{1'b0}}};
					quo_q <= '0;
				end else begin
					acc_q    <= acc_sum;
					mcand_q  <= {mcand_q[CUBE_W-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
				end
			end
			SH_DIV: begin
				quo_q <= {quo_q[MAG_W-2:0], rem_ge};
				if (rem_ge) begin
					rem_q <= rem_q - div_q;
				end
				div_q <= div_q >> 1;
			end
			default: ;
		endcase
	end

	// signed result, held until the next start
	assign quo_ext   = {1'b0, quo_q};
	assign stat.done = state_q == SH_DONE;
	assign stat.pos  = neg_q ? $signed(POS_W'(0) - quo_ext) : $signed(quo_ext);

endmodule

`default_nettype wire

// ===== src/jic_checker.sv =====
// port-level checks for joystick_input_conditioner, attached by bind
// depends on jic_pkg for field widths
`default_nettype none

module jic_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic signed [jic_pkg::POS_W-1:0]     pos_x,
	input wire logic signed [jic_pkg::POS_W-1:0]     pos_y,
	input wire logic                                 fire,
	input wire logic                                 cfg_valid,
	input wire logic                                 cfg_ready
);
	import jic_pkg::*;

	localparam logic [POS_W-1:0] POS_MOST_NEG = {1'b1, {(POS_W-1){1'b0}}};

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(fire))
		else $error("output word changed while stalled");

	// one word in flight: input closes after an accept
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input open the cycle after an accept");

	// the curve never reaches the most negative code
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_x != POS_MOST_NEG) && (pos_y != POS_MOST_NEG))
		else $error("position outside symmetric range");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind joystick_input_conditioner jic_checker u_jic_checker (.*);

`default_nettype wire
